[rtl/qvr_pkg.sv]
// ----------------------------------------------------------------------------
// qvr_pkg
// shared constants and the cordic arctangent table for the vector rotator
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS_DEF    = 16;

  // fixed field widths
  localparam int AXIS_W  = 16;
  localparam int ANGLE_W = 16;

  // cordic datapath: q2.30 values and 32-bit phase, with headroom
  localparam int CORDIC_W   = 34;
  localparam int ATAN_LEN   = 30;
  localparam int CORDIC_GAIN = 652032874;

  // arctangent of 2^-i in phase units, 2^32 is one turn
  function automatic logic signed [CORDIC_W-1:0] atan_phase(input int idx);
    logic signed [CORDIC_W-1:0] v;
    begin
      case (idx)
        0:  v = 34'sd536870912;
        1:  v = 34'sd316933406;
        2:  v = 34'sd167458907;
        3:  v = 34'sd85004756;
        4:  v = 34'sd42667331;
        5:  v = 34'sd21354465;
        6:  v = 34'sd10680862;
        7:  v = 34'sd5340245;
        8:  v = 34'sd2670163;
        9:  v = 34'sd1335087;
        10: v = 34'sd667544;
        11: v = 34'sd333772;
        12: v = 34'sd166886;
        13: v = 34'sd83443;
        14: v = 34'sd41721;
        15: v = 34'sd20860;
        16: v = 34'sd10430;
        17: v = 34'sd5215;
        18: v = 34'sd2607;
        19: v = 34'sd1303;
        20: v = 34'sd651;
        21: v = 34'sd325;
        22: v = 34'sd162;
        23: v = 34'sd81;
        24: v = 34'sd40;
        25: v = 34'sd20;
        26: v = 34'sd10;
        27: v = 34'sd5;
        28: v = 34'sd2;
        29: v = 34'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

[rtl/quaternion_vector_rotate.sv]
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// rotates a q4.12 vector about a q1.14 unit axis by a binary angle, r*P*conj(r)
// ----------------------------------------------------------------------------
//
//  channel | direction | ports                                  | handshake
//  --------+-----------+----------------------------------------+--------------
//  in      | input     | vec_x/y/z, turn_angle, axis_x/y/z      | valid/stall
//  out     | output    | rot_x/y/z                              | valid/stall
//
// one request enters per cycle unless a stall holds the pipeline; it has an
// input register, one stage per cordic step, the rounding stages and two
// quaternion product stages (multiply stage, then add/round stage, each time).
// reset is synchronous and clears only the valid bits of each stage.
// a stall on the output with a result waiting freezes the whole pipeline
// in place and raises in_stall; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate #(
  parameter int COMPONENT_WIDTH = qvr_pkg::COMPONENT_WIDTH_DEF,
  parameter int CORDIC_STEPS    = qvr_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COMPONENT_WIDTH-1:0] in_vec_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_vec_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_vec_z,
  input  logic [qvr_pkg::ANGLE_W-1:0]       in_turn_angle,
  input  logic signed [qvr_pkg::AXIS_W-1:0] in_axis_x,
  input  logic signed [qvr_pkg::AXIS_W-1:0] in_axis_y,
  input  logic signed [qvr_pkg::AXIS_W-1:0] in_axis_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COMPONENT_WIDTH-1:0] out_rot_x,
  output logic signed [COMPONENT_WIDTH-1:0] out_rot_y,
  output logic signed [COMPONENT_WIDTH-1:0] out_rot_z
);
  import qvr_pkg::*;

  localparam int CW  = COMPONENT_WIDTH;
  localparam int N   = CORDIC_STEPS;
  localparam int XW  = CORDIC_W;
  localparam int RW  = 24;               // rotor parts in q2.20 plus headroom
  localparam int MW  = XW + AXIS_W;      // sine times axis
  localparam int PW  = RW + CW;          // rotor times vector product
  localparam int P1W = PW + 3;           // first product sums
  localparam int TW  = P1W - 16;         // first product after rounding
  localparam int QW  = TW + RW;          // second stage product
  localparam int P2W = QW + 3;           // second product sums
  localparam int OW  = P2W - 24;         // result before saturation

  localparam logic signed [XW-1:0]  HALF_C = XW'(512);
  localparam logic signed [MW-1:0]  HALF_M = MW'(1) << 23;
  localparam logic signed [P1W-1:0] HALF_T = P1W'(1) << 15;
  localparam logic signed [P2W-1:0] HALF_O = P2W'(1) << 23;
  localparam logic signed [OW-1:0]  SAT_HI = {{(OW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [OW-1:0]  SAT_LO = ~SAT_HI;

  // output stage valid, drives the pipeline enable
  logic out_valid_r;

  // whole pipeline moves unless a finished result is held back
  logic en;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = out_valid_r && out_stall;

  // cordic stages, index 0 is the input register
  logic                 cv_r  [0:N];
  logic                 cu_r  [0:N];
  logic signed [XW-1:0] cx_r  [0:N];
  logic signed [XW-1:0] cy_r  [0:N];
  logic signed [XW-1:0] cz_r  [0:N];
  logic signed [CW-1:0] cpx_r [0:N];
  logic signed [CW-1:0] cpy_r [0:N];
  logic signed [CW-1:0] cpz_r [0:N];
  logic signed [AXIS_W-1:0] cax_r [0:N];
  logic signed [AXIS_W-1:0] cay_r [0:N];
  logic signed [AXIS_W-1:0] caz_r [0:N];

  // half angle h = angle << 15; top bit picks the upper quarter turn
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (en) begin
      cv_r[0] <= in_valid;
    end
    if (en) begin
      cu_r[0]  <= in_turn_angle[ANGLE_W-1];
      cx_r[0]  <= XW'(CORDIC_GAIN);
      cy_r[0]  <= '0;
      cz_r[0]  <= XW'({in_turn_angle[ANGLE_W-2:0], 15'b0});
      cpx_r[0] <= in_vec_x;
      cpy_r[0] <= in_vec_y;
      cpz_r[0] <= in_vec_z;
      cax_r[0] <= in_axis_x;
      cay_r[0] <= in_axis_y;
      caz_r[0] <= in_axis_z;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    localparam logic signed [XW-1:0] ATAN = atan_phase(i);
    logic signed [XW-1:0] dx, dy;
    logic                 pos;
    assign dx  = cy_r[i] >>> i;
    assign dy  = cx_r[i] >>> i;
    assign pos = !cz_r[i][XW-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else if (en) begin
        cv_r[i+1] <= cv_r[i];
      end
      if (en) begin
        cx_r[i+1]  <= pos ? cx_r[i] - dx : cx_r[i] + dx;
        cy_r[i+1]  <= pos ? cy_r[i] + dy : cy_r[i] - dy;
        cz_r[i+1]  <= pos ? cz_r[i] - ATAN : cz_r[i] + ATAN;
        cu_r[i+1]  <= cu_r[i];
        cpx_r[i+1] <= cpx_r[i];
        cpy_r[i+1] <= cpy_r[i];
        cpz_r[i+1] <= cpz_r[i];
        cax_r[i+1] <= cax_r[i];
        cay_r[i+1] <= cay_r[i];
        caz_r[i+1] <= caz_r[i];
      end
    end
  end

  // stage a: quadrant fix-up, cosine rounded to q2.20
  logic                 va_r;
  logic signed [RW-1:0] ca_r;
  logic signed [XW-1:0] sa_r;
  logic signed [CW-1:0] pax_r, pay_r, paz_r;
  logic signed [AXIS_W-1:0] aax_r, aay_r, aaz_r;
  logic signed [XW-1:0] cos_full, sin_full;

  assign cos_full = cu_r[N] ? -cy_r[N] : cx_r[N];
  assign sin_full = cu_r[N] ? cx_r[N] : cy_r[N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= cv_r[N];
    end
    if (en) begin
      ca_r  <= RW'((cos_full + HALF_C) >>> 10);
      sa_r  <= sin_full;
      pax_r <= cpx_r[N];
      pay_r <= cpy_r[N];
      paz_r <= cpz_r[N];
      aax_r <= cax_r[N];
      aay_r <= cay_r[N];
      aaz_r <= caz_r[N];
    end
  end

  // stage b: rotor vector part, sine times axis rounded to q2.20
  logic                 vb_r;
  logic signed [RW-1:0] rw_r, rx_r, ry_r, rz_r;
  logic signed [CW-1:0] pbx_r, pby_r, pbz_r;
  logic signed [MW-1:0] mx, my, mz;

  assign mx = MW'(sa_r) * MW'(aax_r);
  assign my = MW'(sa_r) * MW'(aay_r);
  assign mz = MW'(sa_r) * MW'(aaz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
    if (en) begin
      rw_r  <= ca_r;
      rx_r  <= RW'((mx + HALF_M) >>> 24);
      ry_r  <= RW'((my + HALF_M) >>> 24);
      rz_r  <= RW'((mz + HALF_M) >>> 24);
      pbx_r <= pax_r;
      pby_r <= pay_r;
      pbz_r <= paz_r;
    end
  end

  // stage c: products of r * P (P has zero scalar part)
  logic                 vc_r;
  logic signed [RW-1:0] rwc_r, rxc_r, ryc_r, rzc_r;
  logic signed [PW-1:0] wx_r, wy_r, wz_r;
  logic signed [PW-1:0] xx_r, xy_r, xz_r;
  logic signed [PW-1:0] yx_r, yy_r, yz_r;
  logic signed [PW-1:0] zx_r, zy_r, zz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
    if (en) begin
      wx_r  <= PW'(rw_r) * PW'(pbx_r);
      wy_r  <= PW'(rw_r) * PW'(pby_r);
      wz_r  <= PW'(rw_r) * PW'(pbz_r);
      xx_r  <= PW'(rx_r) * PW'(pbx_r);
      xy_r  <= PW'(rx_r) * PW'(pby_r);
      xz_r  <= PW'(rx_r) * PW'(pbz_r);
      yx_r  <= PW'(ry_r) * PW'(pbx_r);
      yy_r  <= PW'(ry_r) * PW'(pby_r);
      yz_r  <= PW'(ry_r) * PW'(pbz_r);
      zx_r  <= PW'(rz_r) * PW'(pbx_r);
      zy_r  <= PW'(rz_r) * PW'(pby_r);
      zz_r  <= PW'(rz_r) * PW'(pbz_r);
      rwc_r <= rw_r;
      rxc_r <= rx_r;
      ryc_r <= ry_r;
      rzc_r <= rz_r;
    end
  end

  // stage d: sums of r * P, rounded to q16
  logic                  vd_r;
  logic signed [RW-1:0]  rwd_r, rxd_r, ryd_r, rzd_r;
  logic signed [TW-1:0]  tw_r, tx_r, ty_r, tz_r;
  logic signed [P1W-1:0] sw, sx, sy, sz;

  assign sw = -(P1W'(xx_r) + P1W'(yy_r) + P1W'(zz_r));
  assign sx = P1W'(wx_r) + P1W'(yz_r) - P1W'(zy_r);
  assign sy = P1W'(wy_r) - P1W'(xz_r) + P1W'(zx_r);
  assign sz = P1W'(wz_r) + P1W'(xy_r) - P1W'(yx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
    if (en) begin
      tw_r  <= TW'((sw + HALF_T) >>> 16);
      tx_r  <= TW'((sx + HALF_T) >>> 16);
      ty_r  <= TW'((sy + HALF_T) >>> 16);
      tz_r  <= TW'((sz + HALF_T) >>> 16);
      rwd_r <= rwc_r;
      rxd_r <= rxc_r;
      ryd_r <= ryc_r;
      rzd_r <= rzc_r;
    end
  end

  // stage e: products of t * conj(r), scalar part not needed
  logic                 ve_r;
  logic signed [QW-1:0] twx_r, twy_r, twz_r;
  logic signed [QW-1:0] txw_r, txy_r, txz_r;
  logic signed [QW-1:0] tyw_r, tyx_r, tyz_r;
  logic signed [QW-1:0] tzw_r, tzx_r, tzy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= vd_r;
    end
    if (en) begin
      twx_r <= QW'(tw_r) * QW'(rxd_r);
      twy_r <= QW'(tw_r) * QW'(ryd_r);
      twz_r <= QW'(tw_r) * QW'(rzd_r);
      txw_r <= QW'(tx_r) * QW'(rwd_r);
      txy_r <= QW'(tx_r) * QW'(ryd_r);
      txz_r <= QW'(tx_r) * QW'(rzd_r);
      tyw_r <= QW'(ty_r) * QW'(rwd_r);
      tyx_r <= QW'(ty_r) * QW'(rxd_r);
      tyz_r <= QW'(ty_r) * QW'(rzd_r);
      tzw_r <= QW'(tz_r) * QW'(rwd_r);
      tzx_r <= QW'(tz_r) * QW'(rxd_r);
      tzy_r <= QW'(tz_r) * QW'(ryd_r);
    end
  end

  // stage f: sums, round to q4.12, saturate into the output register
  logic signed [CW-1:0]  out_x_r, out_y_r, out_z_r;
  logic signed [P2W-1:0] ox, oy, oz;
  logic signed [OW-1:0]  qx, qy, qz;

  assign ox = -P2W'(twx_r) + P2W'(txw_r) - P2W'(tyz_r) + P2W'(tzy_r);
  assign oy = -P2W'(twy_r) + P2W'(txz_r) + P2W'(tyw_r) - P2W'(tzx_r);
  assign oz = -P2W'(twz_r) - P2W'(txy_r) + P2W'(tyx_r) + P2W'(tzw_r);
  assign qx = OW'((ox + HALF_O) >>> 24);
  assign qy = OW'((oy + HALF_O) >>> 24);
  assign qz = OW'((oz + HALF_O) >>> 24);

  function automatic logic signed [CW-1:0] sat(input logic signed [OW-1:0] v);
    logic signed [OW-1:0] c;
    begin
      c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
      return CW'(c);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ve_r;
    end
    if (en) begin
      out_x_r <= sat(qx);
      out_y_r <= sat(qy);
      out_z_r <= sat(qz);
    end
  end

  assign out_valid = out_valid_r;
  assign out_rot_x = out_x_r;
  assign out_rot_y = out_y_r;
  assign out_rot_z = out_z_r;

endmodule

[verif/quaternion_vector_rotate_test.sv]
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_test
// drives vectors, angles and axes through the rotator and compares each
// rotated vector against a bit-exact fixed-point prediction
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_test;
  import qvr_pkg::*;

  localparam int CW = COMPONENT_WIDTH_DEF;
  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int LATENCY = STEPS + 7;
  localparam longint QUARTER = 64'sd1073741824;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [15:0] vx, vy, vz;
    logic [15:0] ang;
    logic signed [15:0] ax, ay, az;
  } rot_req_t;

  typedef struct {
    logic signed [CW-1:0] x, y, z;
  } rot_vec_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [CW-1:0] in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  logic [ANGLE_W-1:0] in_turn_angle = '0;
  logic signed [AXIS_W-1:0] in_axis_x = '0, in_axis_y = '0, in_axis_z = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [CW-1:0] out_rot_x, out_rot_y, out_rot_z;

  rot_vec_t expected_rotations[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int cycle_count = 0;

  quaternion_vector_rotate DUT (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // arithmetic shift right (floor) and round half up
  function automatic longint rshift_round(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [CW-1:0] clamp(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  // predicted rotated vector for one request
  function automatic rot_vec_t rotate_vector(rot_req_t q);
    longint h, z, cx, cy, dx, dy, c, s;
    longint rw, rx, ry, rz, px, py, pz;
    longint tw, tx, ty, tz, ox, oy, oz;
    bit upper;
    rot_vec_t r;
    h = longint'(q.ang) <<< 15;
    upper = h >= QUARTER;
    z = upper ? h - QUARTER : h;
    cx = CORDIC_GAIN;
    cy = 0;
    for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= longint'(atan_phase(i));
      end else begin
        cx += dx; cy -= dy; z += longint'(atan_phase(i));
      end
    end
    // upper half of the half-angle range swaps sin and cos
    if (upper) begin
      c = -cy; s = cx;
    end else begin
      c = cx; s = cy;
    end
    rw = rshift_round(c, 10);
    rx = rshift_round(s * longint'(q.ax), 24);
    ry = rshift_round(s * longint'(q.ay), 24);
    rz = rshift_round(s * longint'(q.az), 24);
    px = q.vx; py = q.vy; pz = q.vz;
    // r * P with P.w = 0
    tw = rshift_round(-rx * px - ry * py - rz * pz, 16);
    tx = rshift_round(rw * px + ry * pz - rz * py, 16);
    ty = rshift_round(rw * py - rx * pz + rz * px, 16);
    tz = rshift_round(rw * pz + rx * py - ry * px, 16);
    // t * conj(r)
    ox = tw * -rx + tx * rw + ty * -rz - tz * -ry;
    oy = tw * -ry - tx * -rz + ty * rw + tz * -rx;
    oz = tw * -rz + tx * -ry - ty * -rx + tz * rw;
    r.x = clamp(rshift_round(ox, 24));
    r.y = clamp(rshift_round(oy, 24));
    r.z = clamp(rshift_round(oz, 24));
    return r;
  endfunction

  // receiver side: random stall, or a long hold when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    rot_vec_t exp_v;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rotations.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d %0d %0d", out_rot_x, out_rot_y, out_rot_z);
      end else begin
        exp_v = expected_rotations.pop_front();
        if (exp_v.x !== out_rot_x || exp_v.y !== out_rot_y || exp_v.z !== out_rot_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     exp_v.x, exp_v.y, exp_v.z, out_rot_x, out_rot_y, out_rot_z);
        end
      end
    end
  end

  // send one request; valid stays high across back-to-back requests
  task automatic send_request(rot_req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vec_x <= q.vx; in_vec_y <= q.vy; in_vec_z <= q.vz;
    in_turn_angle <= q.ang;
    in_axis_x <= q.ax; in_axis_y <= q.ay; in_axis_z <= q.az;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_rotations.push_back(rotate_vector(q));
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    go_quiet();
    while (expected_rotations.size() > 0) @(posedge clk);
  endtask

  function automatic rot_req_t make_req(int vx, int vy, int vz, int ang,
                                        int ax, int ay, int az);
    rot_req_t q;
    q.vx = 16'(vx); q.vy = 16'(vy); q.vz = 16'(vz); q.ang = 16'(ang);
    q.ax = 16'(ax); q.ay = 16'(ay); q.az = 16'(az);
    return q;
  endfunction

  // random request: an arbitrary axis, or a unit axis along a coordinate axis or a diagonal, q1.14
  function automatic rot_req_t random_req();
    rot_req_t q;
    int pick;
    q.vx = 16'($urandom); q.vy = 16'($urandom); q.vz = 16'($urandom);
    q.ang = 16'($urandom);
    pick = $urandom_range(9);
    if (pick < 3) begin
      // arbitrary axis, not normalized, exercises saturation
      q.ax = 16'($urandom); q.ay = 16'($urandom); q.az = 16'($urandom);
    end else if (pick < 6) begin
      q.ax = '0; q.ay = '0; q.az = '0;
      case (pick)
        3: q.ax = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        4: q.ay = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        default: q.az = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      endcase
    end else begin
      // diagonal-ish unit axis, 16384/sqrt(3) ~ 9459
      q.ax = $urandom_range(1) ? 16'sd9459 : -16'sd9459;
      q.ay = $urandom_range(1) ? 16'sd9459 : -16'sd9459;
      q.az = $urandom_range(1) ? 16'sd9459 : -16'sd9459;
    end
    // mostly modest vectors so the unit-axis results stay in range
    if (pick >= 3 && $urandom_range(3) != 0) begin
      q.vx = $signed(q.vx) >>> 2; q.vy = $signed(q.vy) >>> 2; q.vz = $signed(q.vz) >>> 2;
    end
    return q;
  endfunction

  task automatic test_directed();
    send_request(make_req(4096, 0, 0, 0, 16384, 0, 0));
    send_request(make_req(4096, 0, 0, 16384, 0, 0, 16384));
    send_request(make_req(0, 4096, 0, 32768, 16384, 0, 0));
    send_request(make_req(0, 0, 4096, 49152, 0, 16384, 0));
    send_request(make_req(4096, 4096, 4096, 65535, 9459, 9459, 9459));
    // half angle just below and at the quarter turn
    send_request(make_req(1000, -2000, 3000, 32767, 0, 0, 16384));
    send_request(make_req(1000, -2000, 3000, 32768, 0, 0, 16384));
    // field extremes
    send_request(make_req(32767, 32767, 32767, 0, 0, 0, 0));
    send_request(make_req(-32768, -32768, -32768, 0, 0, 0, 0));
    send_request(make_req(32767, -32768, 32767, 21845, 16384, 0, 0));
    send_request(make_req(-32768, 32767, -32768, 43690, 0, -16384, 0));
    // axis not unit length, scaled then saturated
    send_request(make_req(20000, 20000, 20000, 8192, 32767, 32767, 32767));
    send_request(make_req(-20000, 15000, 5000, 60000, -32768, -32768, -32768));
    send_request(make_req(1, -1, 1, 1, -32768, 32767, -32768));
    send_request(make_req(0, 0, 0, 65535, 32767, -32768, 32767));
    drain_results();
  endtask

  task automatic test_random(int count);
    repeat (count) send_request(random_req());
    drain_results();
  endtask

  // receiver holds off long enough to fill the pipe and stall the input
  task automatic test_backpressure();
    hold_cycles = 4 * LATENCY;
    repeat (3 * LATENCY) send_request(random_req());
    drain_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle_pct = 33; recv_idle_pct = 51;
    test_random(450);
    send_idle_pct = 51; recv_idle_pct = 33;
    test_random(450);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(400);
    test_backpressure();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && expected_rotations.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
